// ===== src/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants of the firing pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fps_pkg;

    localparam int CHANNEL_COUNT   = 30;
    localparam int SLOTS_PER_ROUND = 3;
    localparam int NAMED_SLOTS     = 3;

    localparam int CHAN_W      = 8;
    localparam int SLOT_CHAN_W = 5;
    localparam int DRIVE_W     = 30;
    localparam int TICK_W      = 16;
    localparam int ELAPSED_W   = 18;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int SLOT_IDX_W  = (SLOTS_PER_ROUND > 1) ? $clog2(SLOTS_PER_ROUND) : 1;

    localparam logic [TICK_W-1:0] SLOT_TICKS_RESET  = TICK_W'(10);
    localparam logic [TICK_W-1:0] FIRE_WINDOW_RESET = TICK_W'(1000);

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_ARM    = 2'd1,
        REQ_DISARM = 2'd2,
        REQ_FIRE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_BUSY    = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_TICKS  = 1'd0,
        CFG_FIRE_WINDOW = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAN_W-1:0] chan_first;
        logic [CHAN_W-1:0] chan_second;
        logic [CHAN_W-1:0] chan_third;
    } in_item_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] channel_drive;
        logic               arm_line;
        logic               busy_res;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } cfg_write_t;

endpackage

`default_nettype wire

// ===== src/fps_core.sv =====
// ----------------------------------------------------------------------------
// fps_core
// Sequencer state and per-item update: arm flag, slot stepping, window check.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire fps_pkg::in_item_t  item,
    input  wire fps_pkg::cfg_write_t cfg,
    output fps_pkg::out_item_t      result
);
    import fps_pkg::*;

    logic [TICK_W-1:0]      slot_ticks_reg;
    logic [TICK_W-1:0]      fire_window_reg;
    logic                   armed_reg, armed_next;
    logic                   firing_reg, firing_next;
    logic [SLOT_CHAN_W-1:0] slot_chan_reg [NAMED_SLOTS];
    logic [SLOT_CHAN_W-1:0] slot_chan_next [NAMED_SLOTS];
    logic [SLOT_IDX_W-1:0]  slot_idx_reg, slot_idx_next;
    logic [TICK_W-1:0]      tick_cnt_reg, tick_cnt_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;

    logic [SLOT_CHAN_W-1:0] cur_chan;
    logic                   cur_named;
    logic [DRIVE_W-1:0]     drive;
    logic [TICK_W-1:0]      slot_len;
    logic [TICK_W:0]        tick_cnt_inc;
    logic [ELAPSED_W-1:0]   elapsed_inc;
    logic                   chan_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ticks_reg  <= SLOT_TICKS_RESET;
            fire_window_reg <= FIRE_WINDOW_RESET;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_SLOT_TICKS:  slot_ticks_reg  <= cfg.data;
                CFG_FIRE_WINDOW: fire_window_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // channel of the current slot, zero past the named slots
    always_comb
    begin
        cur_chan  = '0;
        cur_named = 1'b0;
        for (int i = 0; i < NAMED_SLOTS; i++)
        begin
            if (i < SLOTS_PER_ROUND && slot_idx_reg == SLOT_IDX_W'(i))
            begin
                cur_chan  = slot_chan_reg[i];
                cur_named = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < DRIVE_W; k++)
        begin
            drive[k] = armed_reg && cur_named && (cur_chan == SLOT_CHAN_W'(k + 1));
        end
    end

    assign slot_len     = (slot_ticks_reg == '0) ? TICK_W'(1) : slot_ticks_reg;
    assign tick_cnt_inc = {1'b0, tick_cnt_reg} + (TICK_W+1)'(1);
    assign elapsed_inc  = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + ELAPSED_W'(1);
    assign chan_bad     = (item.chan_first  > CHAN_W'(CHANNEL_COUNT))
                       || (item.chan_second > CHAN_W'(CHANNEL_COUNT))
                       || (item.chan_third  > CHAN_W'(CHANNEL_COUNT));

    always_comb
    begin
        armed_next     = armed_reg;
        firing_next    = firing_reg;
        slot_chan_next = slot_chan_reg;
        slot_idx_next  = slot_idx_reg;
        tick_cnt_next  = tick_cnt_reg;
        elapsed_next   = elapsed_reg;
        result.channel_drive = '0;
        result.status        = STAT_OK;

        if (item.req_type == REQ_TICK)
        begin
            if (firing_reg)
            begin
                result.channel_drive = drive;
                elapsed_next = elapsed_inc;
                if (tick_cnt_inc >= {1'b0, slot_len})
                begin
                    tick_cnt_next = '0;
                    if (slot_idx_reg == SLOT_IDX_W'(SLOTS_PER_ROUND - 1))
                    begin
                        slot_idx_next = '0;
                        if (elapsed_inc >= {{(ELAPSED_W-TICK_W){1'b0}}, fire_window_reg})
                        begin
                            firing_next = 1'b0;
                        end
                    end
                    else
                    begin
                        slot_idx_next = slot_idx_reg + SLOT_IDX_W'(1);
                    end
                end
                else
                begin
                    tick_cnt_next = tick_cnt_inc[TICK_W-1:0];
                end
            end
        end
        else if (item.req_type == REQ_FIRE && chan_bad)
        begin
            result.status = STAT_INVALID;
        end
        else if (firing_reg)
        begin
            result.status = STAT_BUSY;
        end
        else if (item.req_type == REQ_ARM)
        begin
            armed_next = 1'b1;
        end
        else if (item.req_type == REQ_DISARM)
        begin
            armed_next = 1'b0;
        end
        else
        begin
            slot_chan_next[0] = item.chan_first[SLOT_CHAN_W-1:0];
            slot_chan_next[1] = item.chan_second[SLOT_CHAN_W-1:0];
            slot_chan_next[2] = item.chan_third[SLOT_CHAN_W-1:0];
            slot_idx_next     = '0;
            tick_cnt_next     = '0;
            elapsed_next      = '0;
            firing_next       = (fire_window_reg != '0);
        end

        result.arm_line = armed_next;
        result.busy_res = firing_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            firing_reg    <= 1'b0;
            slot_chan_reg <= '{default: '0};
            slot_idx_reg  <= '0;
            tick_cnt_reg  <= '0;
            elapsed_reg   <= '0;
        end
        else if (step)
        begin
            armed_reg     <= armed_next;
            firing_reg    <= firing_next;
            slot_chan_reg <= slot_chan_next;
            slot_idx_reg  <= slot_idx_next;
            tick_cnt_reg  <= tick_cnt_next;
            elapsed_reg   <= elapsed_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/firing_pulse_sequencer.sv =====
// ----------------------------------------------------------------------------
// firing_pulse_sequencer
// Ignition channel sequencer: arm/disarm, fire requests and slot-timed pulses.
// ----------------------------------------------------------------------------
// Every input transfer (tick, arm, disarm or fire) produces exactly one result
// transfer. The item is evaluated against the sequencer state in the cycle it
// is taken; its result is registered in the output register as it is taken.
// A new item is taken every cycle unless a result sits unclaimed there, so
// throughput is one item per clock. Slot length and firing window must be
// written through the cfg port only while no item is pending; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module firing_pulse_sequencer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire fps_pkg::in_item_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output fps_pkg::out_item_t              out_data,
    input  wire logic                       cfg_we,
    input  wire logic [fps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fps_pkg::CFG_W-1:0]  cfg_data
);
    import fps_pkg::*;

    logic       out_valid_reg;
    out_item_t  out_data_reg;
    out_item_t  result;
    cfg_write_t cfg;
    logic       step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    fps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
